// ----- hw/rtl/pckg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_pkg
// Shared types, constants and the arctangent table of the pose change
// keyframe gate.
// ----------------------------------------------------------------------------
package pckg_pkg;

    // defaults and limits
    localparam int ANGLE_ITER_DEFAULT = 16;
    localparam int ATAN_LEN           = 24;
    localparam int ATAN_W             = 22;
    localparam int ZW                 = 26;
    localparam int DEG180_Q16         = 11796480;
    localparam int QUEUE_DEPTH        = 2;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_THR  = 2'd1;
    localparam logic [31:0] DIST_THR_RESET = 32'd6554;
    localparam logic [14:0] ANG_THR_RESET  = 15'd640;

    // input word
    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pose_in_t;

    // result word
    typedef struct packed {
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
        logic signed [15:0] out_quat_w;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
    } pose_out_t;

    // classified pose handed from front to back
    typedef struct packed {
        pose_in_t           pose;
        logic signed [31:0] m00;
        logic signed [31:0] m10;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic        [63:0] pos_sq;
    } work_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pckg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_front
// Accepts a pose word, forms the quaternion products and the squared position
// with one shared multiplier, builds the rotation matrix terms and queues them.
// ----------------------------------------------------------------------------
module pckg_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pckg_pkg::pose_in_t s_data,
    output logic                   push,
    output pckg_pkg::work_t        push_data,
    input  wire logic              q_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    // product tags
    localparam logic [3:0] T_WW = 4'd0;
    localparam logic [3:0] T_XX = 4'd1;
    localparam logic [3:0] T_YY = 4'd2;
    localparam logic [3:0] T_ZZ = 4'd3;
    localparam logic [3:0] T_XY = 4'd4;
    localparam logic [3:0] T_ZW = 4'd5;
    localparam logic [3:0] T_XZ = 4'd6;
    localparam logic [3:0] T_YW = 4'd7;
    localparam logic [3:0] T_YZ = 4'd8;
    localparam logic [3:0] T_XW = 4'd9;
    localparam logic [3:0] T_PX = 4'd10;
    localparam logic [3:0] T_PY = 4'd11;
    localparam logic [3:0] T_PZ = 4'd12;
    localparam int NUM_QP = 10;

    logic [1:0]          state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                pvld_reg, pvld_next;
    logic [3:0]          tag_reg;
    logic signed [63:0]  prod_reg;
    logic signed [31:0]  qp_reg [NUM_QP];
    logic [63:0]         psq_reg;
    pckg_pkg::pose_in_t  pose_reg;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [33:0]  s00, s10, s20, s21, s22, t00, t10, t20, t21, t22;

    // operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cnt_reg)
            T_WW: begin mul_a = 32'(pose_reg.quat_w); mul_b = 32'(pose_reg.quat_w); end
            T_XX: begin mul_a = 32'(pose_reg.quat_x); mul_b = 32'(pose_reg.quat_x); end
            T_YY: begin mul_a = 32'(pose_reg.quat_y); mul_b = 32'(pose_reg.quat_y); end
            T_ZZ: begin mul_a = 32'(pose_reg.quat_z); mul_b = 32'(pose_reg.quat_z); end
            T_XY: begin mul_a = 32'(pose_reg.quat_x); mul_b = 32'(pose_reg.quat_y); end
            T_ZW: begin mul_a = 32'(pose_reg.quat_z); mul_b = 32'(pose_reg.quat_w); end
            T_XZ: begin mul_a = 32'(pose_reg.quat_x); mul_b = 32'(pose_reg.quat_z); end
            T_YW: begin mul_a = 32'(pose_reg.quat_y); mul_b = 32'(pose_reg.quat_w); end
            T_YZ: begin mul_a = 32'(pose_reg.quat_y); mul_b = 32'(pose_reg.quat_z); end
            T_XW: begin mul_a = 32'(pose_reg.quat_x); mul_b = 32'(pose_reg.quat_w); end
            T_PX: begin mul_a = pose_reg.pos_x; mul_b = pose_reg.pos_x; end
            T_PY: begin mul_a = pose_reg.pos_y; mul_b = pose_reg.pos_y; end
            T_PZ: begin mul_a = pose_reg.pos_z; mul_b = pose_reg.pos_z; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // rotation matrix terms, floor shifted
    always_comb begin
        s00 = 34'(qp_reg[T_WW]) + 34'(qp_reg[T_XX]) - 34'(qp_reg[T_YY]) - 34'(qp_reg[T_ZZ]);
        s22 = 34'(qp_reg[T_WW]) - 34'(qp_reg[T_XX]) - 34'(qp_reg[T_YY]) + 34'(qp_reg[T_ZZ]);
        s10 = 34'(qp_reg[T_XY]) + 34'(qp_reg[T_ZW]);
        s20 = 34'(qp_reg[T_XZ]) - 34'(qp_reg[T_YW]);
        s21 = 34'(qp_reg[T_YZ]) + 34'(qp_reg[T_XW]);
        t00 = s00 >>> 2;
        t22 = s22 >>> 2;
        t10 = s10 >>> 1;
        t20 = s20 >>> 1;
        t21 = s21 >>> 1;
        push_data.pose   = pose_reg;
        push_data.m00    = t00[31:0];
        push_data.m10    = t10[31:0];
        push_data.m20    = t20[31:0];
        push_data.m21    = t21[31:0];
        push_data.m22    = t22[31:0];
        push_data.pos_sq = psq_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pvld_next  = 1'b0;
        s_ready    = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                if (cnt_reg <= T_PZ) begin
                    pvld_next = 1'b1;
                    cnt_next  = cnt_reg + 4'd1;
                end
                if (pvld_reg && tag_reg == T_PZ) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            pvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pvld_reg  <= pvld_next;
        end
    end

    // multiplier, product store and word capture
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        tag_reg  <= cnt_reg;
        if (s_valid && s_ready) begin
            pose_reg <= s_data;
            psq_reg  <= '0;
        end else if (pvld_reg) begin
            if (tag_reg < T_PX) begin
                qp_reg[tag_reg] <= prod_reg[31:0];
            end else begin
                psq_reg <= psq_reg + 64'(prod_reg);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pckg_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_queue
// Short queue of classified poses between the front and the back.
// ----------------------------------------------------------------------------
module pckg_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire pckg_pkg::work_t  push_data,
    output logic                  q_ready,
    output logic                  q_valid,
    output pckg_pkg::work_t       q_data,
    input  wire logic             pop
);

    localparam int DEPTH = pckg_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    pckg_pkg::work_t  mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign q_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pckg_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_sqrt
// Floor square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module pckg_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [32:0]      root
);

    logic        busy_reg, done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [63:0] trial, v_next, r_next;

    // one restoring step
    always_comb begin
        trial = r_reg + bit_reg;
        if (v_reg >= trial) begin
            v_next = v_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end else begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end
    end

    assign done = done_reg;
    assign root = r_reg[32:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pckg_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, result in degrees Q9.7.
// ----------------------------------------------------------------------------
module pckg_cordic #(
    parameter int ANGLE_ITERATIONS = pckg_pkg::ANGLE_ITER_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] y_in,
    input  wire logic signed [31:0] x_in,
    output logic                    done,
    output logic signed [15:0]      angle
);

    localparam int XW    = 36;
    localparam int ZW    = pckg_pkg::ZW;
    localparam int CNT_W = $clog2(ANGLE_ITERATIONS);
    localparam logic signed [ZW-1:0] DEG_Z = ZW'(pckg_pkg::DEG180_Q16);
    localparam logic signed [ZW-1:0] HALF  = ZW'(256);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys, x_ext, y_ext;
    logic signed [ZW-1:0] z_reg, z_next, at, zr;

    assign x_ext = {{(XW-32){x_in[31]}}, x_in};
    assign y_ext = {{(XW-32){y_in[31]}}, y_in};

    // micro-rotation
    always_comb begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = {{(ZW-pckg_pkg::ATAN_W){1'b0}}, pckg_pkg::atan_deg_q16(5'(cnt_reg))};
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (y_reg > 0) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end else if (y_reg < 0) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
    end

    // round to Q9.7
    assign zr    = (z_reg + HALF) >>> 9;
    assign angle = zr[15:0];
    assign done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ANGLE_ITERATIONS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, left half-plane folded by 180 degrees
    always_ff @(posedge aclk) begin
        if (start) begin
            if (x_in < 0) begin
                x_reg <= -x_ext;
                y_reg <= -y_ext;
                z_reg <= (y_in >= 0) ? DEG_Z : -DEG_Z;
            end else begin
                x_reg <= x_ext;
                y_reg <= y_ext;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pckg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pckg_back
// Takes classified poses from the queue, derives norm, roll, pitch and yaw,
// compares with the last keyframe and emits the pose when it moved enough.
// ----------------------------------------------------------------------------
module pckg_back #(
    parameter int ANGLE_ITERATIONS = pckg_pkg::ANGLE_ITER_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire pckg_pkg::work_t   q_data,
    output logic                   pop,
    input  wire logic [31:0]       dist_thr,
    input  wire logic [14:0]       ang_thr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pckg_pkg::pose_out_t    m_data
);

    localparam logic [3:0] B_IDLE    = 4'd0;
    localparam logic [3:0] B_DIST_W  = 4'd1;
    localparam logic [3:0] B_ROLL_W  = 4'd2;
    localparam logic [3:0] B_MUL0    = 4'd3;
    localparam logic [3:0] B_MUL1    = 4'd4;
    localparam logic [3:0] B_MADD    = 4'd5;
    localparam logic [3:0] B_PDEN_W  = 4'd6;
    localparam logic [3:0] B_PITCH_W = 4'd7;
    localparam logic [3:0] B_YAW_W   = 4'd8;
    localparam logic [3:0] B_DECIDE  = 4'd9;
    localparam logic [3:0] B_OUT     = 4'd10;

    logic [3:0]          state_reg, state_next;
    pckg_pkg::work_t     work_reg;
    logic [31:0]         dist_reg, last_dist_reg;
    logic signed [15:0]  roll_reg, pitch_reg, yaw_reg;
    logic signed [15:0]  last_roll_reg, last_pitch_reg, last_yaw_reg;
    logic signed [63:0]  prod_reg, acc_reg;
    logic signed [31:0]  mul_a;
    logic                m_valid_reg;
    pckg_pkg::pose_out_t m_data_reg;

    logic                sq_start, sq_done;
    logic [63:0]         sq_value;
    logic [32:0]         sq_root;
    logic                cd_start, cd_done;
    logic signed [31:0]  cd_y, cd_x;
    logic signed [15:0]  cd_angle;
    logic [31:0]         dist_sat, dd;
    logic signed [16:0]  dr, dp, dy;
    logic [16:0]         ar, ap, ay, amax;
    logic                keep;

    pckg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sq_value),
        .done    (sq_done),
        .root    (sq_root)
    );

    pckg_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .y_in    (cd_y),
        .x_in    (cd_x),
        .done    (cd_done),
        .angle   (cd_angle)
    );

    assign dist_sat = sq_root[32] ? 32'hFFFF_FFFF : sq_root[31:0];
    assign mul_a    = (state_reg == B_MUL0) ? work_reg.m21 : work_reg.m22;

    // change against last keyframe
    always_comb begin
        dd   = (dist_reg >= last_dist_reg) ? dist_reg - last_dist_reg
                                           : last_dist_reg - dist_reg;
        dr   = 17'(roll_reg) - 17'(last_roll_reg);
        dp   = 17'(pitch_reg) - 17'(last_pitch_reg);
        dy   = 17'(yaw_reg) - 17'(last_yaw_reg);
        ar   = dr[16] ? 17'(-dr) : 17'(dr);
        ap   = dp[16] ? 17'(-dp) : 17'(dp);
        ay   = dy[16] ? 17'(-dy) : 17'(dy);
        amax = ar;
        if (ap > amax) begin
            amax = ap;
        end
        if (ay > amax) begin
            amax = ay;
        end
        keep = (dd > dist_thr) || (amax > {2'b00, ang_thr});
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        sq_start   = 1'b0;
        sq_value   = q_data.pos_sq;
        cd_start   = 1'b0;
        cd_y       = work_reg.m21;
        cd_x       = work_reg.m22;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    sq_start   = 1'b1;
                    state_next = B_DIST_W;
                end
            end
            B_DIST_W: begin
                if (sq_done) begin
                    cd_start   = 1'b1;
                    state_next = B_ROLL_W;
                end
            end
            B_ROLL_W: begin
                if (cd_done) begin
                    state_next = B_MUL0;
                end
            end
            B_MUL0: state_next = B_MUL1;
            B_MUL1: state_next = B_MADD;
            B_MADD: begin
                sq_start   = 1'b1;
                sq_value   = 64'(acc_reg) + 64'(prod_reg);
                state_next = B_PDEN_W;
            end
            B_PDEN_W: begin
                if (sq_done) begin
                    cd_start   = 1'b1;
                    cd_y       = -work_reg.m20;
                    cd_x       = sq_root[31:0];
                    state_next = B_PITCH_W;
                end
            end
            B_PITCH_W: begin
                if (cd_done) begin
                    cd_start   = 1'b1;
                    cd_y       = work_reg.m10;
                    cd_x       = work_reg.m00;
                    state_next = B_YAW_W;
                end
            end
            B_YAW_W: begin
                if (cd_done) begin
                    state_next = B_DECIDE;
                end
            end
            B_DECIDE: state_next = keep ? B_OUT : B_IDLE;
            B_OUT: begin
                if (!m_valid_reg) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control and keyframe state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            m_valid_reg    <= 1'b0;
            last_dist_reg  <= '0;
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
            last_yaw_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_DECIDE && keep) begin
                last_dist_reg  <= dist_reg;
                last_roll_reg  <= roll_reg;
                last_pitch_reg <= pitch_reg;
                last_yaw_reg   <= yaw_reg;
            end
            if (state_reg == B_OUT && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_a;
        if (state_reg == B_MUL1) begin
            acc_reg <= prod_reg;
        end
        if (pop) begin
            work_reg <= q_data;
        end
        if (state_reg == B_DIST_W && sq_done) begin
            dist_reg <= dist_sat;
        end
        if (state_reg == B_ROLL_W && cd_done) begin
            roll_reg <= cd_angle;
        end
        if (state_reg == B_PITCH_W && cd_done) begin
            pitch_reg <= cd_angle;
        end
        if (state_reg == B_YAW_W && cd_done) begin
            yaw_reg <= cd_angle;
        end
        if (state_reg == B_OUT && !m_valid_reg) begin
            m_data_reg.out_quat_x <= work_reg.pose.quat_x;
            m_data_reg.out_quat_y <= work_reg.pose.quat_y;
            m_data_reg.out_quat_z <= work_reg.pose.quat_z;
            m_data_reg.out_quat_w <= work_reg.pose.quat_w;
            m_data_reg.out_pos_x  <= work_reg.pose.pos_x;
            m_data_reg.out_pos_y  <= work_reg.pose.pos_y;
            m_data_reg.out_pos_z  <= work_reg.pose.pos_z;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/pose_change_keyframe_gate_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pose_change_keyframe_gate_unit
// Keyframe gate: passes an odometry pose on only when its translation norm or
// one of its Euler angles moved past a threshold since the last keyframe.
//
//   channel  dir  handshake          word
//   s_       in   s_valid/s_ready    pose_in_t  (quaternion Q1.15, position Q16.16)
//   m_       out  m_valid/m_ready    pose_out_t (the kept pose, unchanged)
//   cfg_     in   cfg_valid/ready    cfg_index, cfg_data (thresholds)
//
// The front forms its 13 products on one multiplier and takes a new word only
// after the last one is pushed to the queue. The back runs the 32-step square
// root unit twice and the CORDIC unit three times for each word.
// A two-word queue sits between front and back; the result register lets the
// back start the next word while a result waits. Reset is synchronous, active
// low, and brings back the identity pose and default thresholds.
// ----------------------------------------------------------------------------
module pose_change_keyframe_gate_unit #(
    parameter int ANGLE_ITERATIONS = pckg_pkg::ANGLE_ITER_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire pckg_pkg::pose_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output pckg_pkg::pose_out_t                     m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pckg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    logic [31:0]      dist_thr_reg;
    logic [14:0]      ang_thr_reg;
    logic             push, q_ready, q_valid, pop;
    pckg_pkg::work_t  push_data, q_data;

    // threshold registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_thr_reg <= pckg_pkg::DIST_THR_RESET;
            ang_thr_reg  <= pckg_pkg::ANG_THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == pckg_pkg::CFG_DIST_THR) begin
                dist_thr_reg <= cfg_data;
            end else if (cfg_index == pckg_pkg::CFG_ANG_THR) begin
                ang_thr_reg <= cfg_data[14:0];
            end
        end
    end

    pckg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready)
    );

    pckg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    pckg_back #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .dist_thr (dist_thr_reg),
        .ang_thr  (ang_thr_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pose change keyframe gate: random bursty poses
// against a behavioural predictor of the gate decision, with a random-stall
// result side, threshold changes between phases and a cycle watchdog.
// ----------------------------------------------------------------------------

// keyframe scoreboard: holds the predictor state and the kept poses
class keyframe_board;
    bit [31:0] dist_thr;
    bit [14:0] ang_thr;
    int signed kf_roll, kf_pitch, kf_yaw;
    bit [31:0] kf_norm;
    pckg_pkg::pose_out_t kept_q[$];
    int        errors;

    function new();
        dist_thr = pckg_pkg::DIST_THR_RESET;
        ang_thr  = pckg_pkg::ANG_THR_RESET;
        kf_roll = 0; kf_pitch = 0; kf_yaw = 0; kf_norm = 0;
        errors = 0;
    endfunction

    static function longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, degrees q9.7
    static function int signed angle_of(longint y, longint x);
        longint z, xs, ys;
        longint tbl[24];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
                1, 0};
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? pckg_pkg::DEG180_Q16 : -pckg_pkg::DEG180_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < pckg_pkg::ANGLE_ITER_DEFAULT && i < 24; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += tbl[i];
            end else if (y < 0) begin
                x -= ys; y += xs; z -= tbl[i];
            end
        end
        return int'(fshr(z + 256, 9));
    endfunction

    static function int unsigned adiff(int signed a, int signed b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // note an accepted pose, predict whether it becomes a keyframe
    function void note_pose(pckg_pkg::pose_in_t p);
        longint qx, qy, qz, qw, px, py, pz, m00, m10, m20, m21, m22;
        longint unsigned sq, n64;
        bit [31:0] n, dd;
        int signed r, pt, yw;
        int unsigned da, t;
        pckg_pkg::pose_out_t o;
        qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
        px = p.pos_x; py = p.pos_y; pz = p.pos_z;
        m00 = fshr(qw*qw + qx*qx - qy*qy - qz*qz, 2);
        m10 = fshr(2*(qx*qy + qz*qw), 2);
        m20 = fshr(2*(qx*qz - qy*qw), 2);
        m21 = fshr(2*(qy*qz + qx*qw), 2);
        m22 = fshr(qw*qw - qx*qx - qy*qy + qz*qz, 2);
        r  = angle_of(m21, m22);
        sq = longint'(m21*m21) + longint'(m22*m22);
        pt = angle_of(-m20, longint'(root64(sq)));
        yw = angle_of(m10, m00);
        sq = longint'(px*px) + longint'(py*py) + longint'(pz*pz);
        n64 = root64(sq);
        n = (n64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n64[31:0];
        dd = (n >= kf_norm) ? n - kf_norm : kf_norm - n;
        da = adiff(r, kf_roll);
        t = adiff(pt, kf_pitch); if (t > da) da = t;
        t = adiff(yw, kf_yaw);   if (t > da) da = t;
        if (!(dd > dist_thr || da > ang_thr)) return;
        kf_roll = r; kf_pitch = pt; kf_yaw = yw; kf_norm = n;
        o = p;
        kept_q.push_back(o);
    endfunction

    // compare a result with the oldest kept pose
    function void check_result(pckg_pkg::pose_out_t a);
        pckg_pkg::pose_out_t e;
        if (kept_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            errors++;
            return;
        end
        e = kept_q.pop_front();
        if (a.out_quat_x !== e.out_quat_x) begin
            $display("%0t: quat_x exp %h act %h", $time, e.out_quat_x, a.out_quat_x); errors++; end
        if (a.out_quat_y !== e.out_quat_y) begin
            $display("%0t: quat_y exp %h act %h", $time, e.out_quat_y, a.out_quat_y); errors++; end
        if (a.out_quat_z !== e.out_quat_z) begin
            $display("%0t: quat_z exp %h act %h", $time, e.out_quat_z, a.out_quat_z); errors++; end
        if (a.out_quat_w !== e.out_quat_w) begin
            $display("%0t: quat_w exp %h act %h", $time, e.out_quat_w, a.out_quat_w); errors++; end
        if (a.out_pos_x !== e.out_pos_x) begin
            $display("%0t: pos_x exp %h act %h", $time, e.out_pos_x, a.out_pos_x); errors++; end
        if (a.out_pos_y !== e.out_pos_y) begin
            $display("%0t: pos_y exp %h act %h", $time, e.out_pos_y, a.out_pos_y); errors++; end
        if (a.out_pos_z !== e.out_pos_z) begin
            $display("%0t: pos_z exp %h act %h", $time, e.out_pos_z, a.out_pos_z); errors++; end
    endfunction
endclass

module tb_top;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pckg_pkg::pose_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pckg_pkg::pose_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pckg_pkg::CFG_IDX_W-1:0] cfg_index = pckg_pkg::CFG_DIST_THR;
    logic [31:0] cfg_data = '0;

    keyframe_board board;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;
    int idle_cycles = 0;

    pose_change_keyframe_gate_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // result side: score accepted words, stall on a pattern of its own
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_result(m_data);
            if (s_valid && s_ready || m_valid && m_ready || cfg_valid && cfg_ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int mode;
        forever begin
            @(posedge aclk);
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                if (hold_off) m_ready <= 1'b0;
                else if (mode == 0) m_ready <= 1'b1;
                else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
                else if (mode == 2) m_ready <= ($urandom_range(0, 3) == 0);
                else m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays up from word to word inside a burst
    task automatic send_pose(pckg_pkg::pose_in_t p);
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pose(p);
    endtask

    // drop valid at the end of a burst
    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [pckg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == pckg_pkg::CFG_DIST_THR) board.dist_thr = val;
        else board.ang_thr = val[14:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for the kept poses, then let the back end finish any dropped words
    task automatic drain();
        while (board.kept_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic pckg_pkg::pose_in_t make_pose(input int kind);
        pckg_pkg::pose_in_t p;
        int sc;
        p.quat_x = 16'($urandom); p.quat_y = 16'($urandom);
        p.quat_z = 16'($urandom); p.quat_w = 16'($urandom);
        p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
        if (kind != 0) begin
            // small motion: poses near the identity rotation and the origin
            sc = $urandom_range(4, 12);
            p.quat_x = $signed(p.quat_x) >>> sc;
            p.quat_y = $signed(p.quat_y) >>> sc;
            p.quat_z = $signed(p.quat_z) >>> sc;
            p.quat_w = 16'sd32000 - 16'($urandom_range(0, 255));
            sc = $urandom_range(10, 24);
            p.pos_x = $signed(p.pos_x) >>> sc;
            p.pos_y = $signed(p.pos_y) >>> sc;
            p.pos_z = $signed(p.pos_z) >>> sc;
        end
        return p;
    endfunction

    initial begin : stimulus
        int n;
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero and unnormalised quaternions, negative x, equal threshold
        send_pose('0);
        send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 32'sd6554, 32'sd0, 32'sd0});
        send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 32'sd13109, 32'sd0, 32'sd0});
        send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd4, 32'sd13109, 32'sd0, 32'sd0});
        send_pose('{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_pose('{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_pose('{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_pose('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                    -32'sd2147483648, -32'sd2147483648, -32'sd2147483648});
        send_pose('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                    32'sd2147483647, 32'sd2147483647, 32'sd2147483647});
        send_pose('{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 32'sd1, -32'sd1, 32'sd0});
        send_pose('{16'sd100, -16'sd200, 16'sd0, -16'sd30000, -32'sd65536, 32'sd0, 32'sd0});
        send_pose('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 32'sd0, 32'sd65536, 32'sd0});
        send_pose('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 32'sd0, 32'sd0, 32'sd65536});
        end_burst();
        drain();

        // random phases over several threshold settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(pckg_pkg::CFG_DIST_THR, 32'd0);
                    write_reg(pckg_pkg::CFG_ANG_THR, 32'd0);
                end
                1: begin
                    write_reg(pckg_pkg::CFG_DIST_THR, 32'hFFFF_FFFF);
                    write_reg(pckg_pkg::CFG_ANG_THR, 32'h7FFF);
                end
                2: begin
                    write_reg(pckg_pkg::CFG_DIST_THR, pckg_pkg::DIST_THR_RESET);
                    write_reg(pckg_pkg::CFG_ANG_THR, 32'(pckg_pkg::ANG_THR_RESET));
                end
                default: begin
                    write_reg(pckg_pkg::CFG_DIST_THR, $urandom_range(0, 200000));
                    write_reg(pckg_pkg::CFG_ANG_THR, $urandom_range(0, 4000));
                end
            endcase
            n = 0;
            while (n < 250) begin
                repeat ($urandom_range(1, 12)) begin
                    send_pose(make_pose($urandom_range(0, 4)));
                    n++;
                end
                end_burst();
                if ($urandom_range(0, 1)) repeat ($urandom_range(1, 300)) @(posedge aclk);
                // long receiver hold-off while poses keep arriving
                if (ph == 3 && n > 100 && n < 115) begin
                    hold_off = 1'b1;
                    fork
                        begin repeat (3000) @(posedge aclk); hold_off = 1'b0; end
                    join_none
                end
                // pause until every kept pose has come out
                if (ph == 4 && n > 100 && n < 115) begin
                    while (board.kept_q.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (board.errors == 0 && board.kept_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
